[src/ssrc_pkg.sv]
package ssrc_pkg;

  // Shared serial multiplier operand widths.
  localparam int MUL_AW = 32;
  localparam int MUL_BW = 18;

  // Smoothstep constant 3.0 in Q2.16.
  localparam logic [MUL_BW-1:0] EASE_K = 18'd196608;

  // Input payload layout.
  localparam int S_DATA_W = 56;

  // Operation codes carried on s_tuser.
  localparam logic OP_MOVE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] REG_PULSE_MIN  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_PULSE_MAX  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_PWM_PERIOD = 3'd2;
  localparam logic [CFG_AW-1:0] REG_RAMP_TIME  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_RAMP_STEP  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_SETTLE     = 3'd5;

endpackage

[src/ssrc_smul.sv]
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
module ssrc_smul import ssrc_pkg::*; #(
  parameter int AW = 32,
  parameter int BW = 18
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic [AW+BW-1:0] prod,
  output logic            done
);

  localparam int CW = (BW > 1) ? $clog2(BW) : 1;

  logic [AW-1:0]    a_r;
  logic [AW+BW-1:0] acc;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [AW:0]      sum;

  assign sum  = {1'b0, acc[AW+BW-1:BW]} + (acc[0] ? {1'b0, a_r} : '0);
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r  <= a;
        acc  <= {{AW{1'b0}}, b};
        cnt  <= CW'(BW - 1);
        busy <= 1'b1;
      end else if (busy) begin
        // The low bits hold the multiplier still to be consumed.
        acc <= {sum, acc[BW-1:1]};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/ssrc_sdiv.sv]
// Restoring divider: one quotient bit per cycle. Expects num < den << QB.
module ssrc_sdiv import ssrc_pkg::*; #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QB = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] quo,
  output logic          done
);

  localparam int CW = (QB > 1) ? $clog2(QB) : 1;

  logic [NW-1:0] rem;
  logic [NW-1:0] dsh;
  logic [QB-1:0] q;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          fits;

  assign fits = (rem >= dsh);
  assign quo  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num;
        dsh  <= NW'(den) << (QB - 1);
        q    <= '0;
        cnt  <= CW'(QB - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= rem - dsh;
        end
        q   <= {q[QB-2:0], fits};
        dsh <= dsh >> 1;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/servo_smoothstep_ramp_controller_top.sv]
// Channel     | Handshake          | Payload
// ------------+--------------------+-----------------------------------------------
// input       | s_tvalid/s_tready  | s_tuser = op; s_tdata = time_ms, goal_angle,
//             |                    |   forced
// result      | m_tvalid/m_tready  | m_tdata = duty, duty_written, angle_now,
//             |                    |   angle_goal, moving
// config      | cfg_we             | cfg_addr = register index, cfg_wdata = value
//
// One input transaction is taken at a time and gives exactly one result transaction.
// A tick that samples nothing, or an ignored command, goes from S_DECODE straight back
// to S_IDLE. A duty update takes three passes of the shared bit-serial multiplier and
// one of the serial divider, which is skipped when the duty saturates. A ramp sample
// adds the S_RAMP and S_NEXT states and, while the ramp time has not run out, a pass
// of the ramp divider and three more multiplier passes.
// After the synchronous reset the block works out the duty for 90 degrees and
// accepts no input transaction until then.
// The result sits in an output register; while it is stalled the input side is free
// again, but a next result waits in the block and holds off input until it is taken.
module servo_smoothstep_ramp_controller_top import ssrc_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 4,
  parameter int DUTY_BITS       = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_DW-1:0]   cfg_wdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  // s_tdata, low bit up: time_ms[31:0], goal_angle[47:32], forced[48], zeros
  input  logic [S_DATA_W-1:0] s_tdata,
  // s_tuser: op
  input  logic                s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // m_tdata, low bit up: duty, duty_written, angle_now, angle_goal, moving, zeros
  output logic [((DUTY_BITS + 2*(ANGLE_FRAC_BITS + 8) + 2 + 7) / 8) * 8 - 1:0] m_tdata
);

  // Angles carry ANGLE_FRAC_BITS fraction bits; 180 degrees needs 8 integer bits.
  localparam int AW    = ANGLE_FRAC_BITS + 8;
  localparam int DB    = DUTY_BITS;
  localparam int PW    = 24 + ANGLE_FRAC_BITS;   // pulse or period times A180
  localparam int NWID  = PW + DB + 2;             // rounded duty dividend
  localparam int OUT_W = ((DB + 2*AW + 2 + 7) / 8) * 8;
  localparam logic [AW-1:0] A180 = AW'(180 << ANGLE_FRAC_BITS);
  localparam logic [AW-1:0] A90  = AW'(90 << ANGLE_FRAC_BITS);
  localparam logic [AW-1:0] AEPS = AW'(1 << (ANGLE_FRAC_BITS - 1));
  localparam logic [DB-1:0] DMAX = '1;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DECODE = 13'b0000000000010,
    S_RAMP   = 13'b0000000000100,
    S_PDIV   = 13'b0000000001000,
    S_MPP    = 13'b0000000010000,
    S_MEASE  = 13'b0000000100000,
    S_MD     = 13'b0000001000000,
    S_NEXT   = 13'b0000010000000,
    S_MDEN   = 13'b0000100000000,
    S_MLO    = 13'b0001000000000,
    S_MHI    = 13'b0010000000000,
    S_SAT    = 13'b0100000000000,
    S_QDIV   = 13'b1000000000000
  } state_t;

  // S_DONE is folded into S_IDLE handling below would block acceptance, so the
  // final hand-over uses its own flag instead of a separate state.
  state_t state;
  logic   pend;

  // Configuration registers.
  logic [15:0] pulse_min, pulse_max, pwm_period, ramp_time, ramp_step, settle_time;

  // Controller state.
  logic [AW-1:0] cur_angle, tgt_angle, ramp_origin;
  logic [31:0]   command_stamp, last_step_stamp, settle_stamp;
  logic          in_motion, goal_reached, wrote, booting;
  logic [DB-1:0] duty_reg;

  // Captured input transaction.
  logic               op_r, force_r;
  logic [31:0]        now_r;
  logic signed [15:0] goal_r;

  // Working registers.
  logic [15:0]     p_r;
  logic [AW-1:0]   next_r, duty_a;
  logic [PW-1:0]   den_r, lo_r;
  logic [NWID-1:0] num_r;

  // Serial units.
  logic                     mul_start, mul_done;
  logic [MUL_AW-1:0]        mul_a;
  logic [MUL_BW-1:0]        mul_b;
  logic [MUL_AW+MUL_BW-1:0] mul_prod;
  logic                     pdiv_start, pdiv_done;
  logic [15:0]              pdiv_q;
  logic                     qdiv_start, qdiv_done;
  logic [DB-1:0]            qdiv_q;

  // Combinational helpers.
  logic [31:0]     elapsed;
  logic [AW-1:0]   goal_c, goal_dist, ramp_dist, next_dist, final_angle, dval;
  logic            same;
  logic [15:0]     per_eff;
  logic [AW+16:0]  rnd;
  logic [PW:0]     psum;
  logic [PW+DB:0]  numv;
  logic [NWID-1:0] nv;
  logic            sat;

  assign elapsed = now_r - command_stamp;
  assign per_eff = (pwm_period == 16'd0) ? 16'd1 : pwm_period;

  // A negative request clamps to zero, anything past 180 degrees to 180.
  always_comb begin
    if (goal_r[15]) begin
      goal_c = '0;
    end else if ($unsigned(goal_r) > 16'(A180)) begin
      goal_c = A180;
    end else begin
      goal_c = goal_r[AW-1:0];
    end
  end

  assign goal_dist = (goal_c >= tgt_angle) ? goal_c - tgt_angle : tgt_angle - goal_c;
  assign same      = (goal_dist <= AEPS);
  assign ramp_dist = (tgt_angle >= ramp_origin) ? tgt_angle - ramp_origin
                                                : ramp_origin - tgt_angle;
  assign next_dist = (next_r >= tgt_angle) ? next_r - tgt_angle : tgt_angle - next_r;
  assign final_angle = (next_dist <= AEPS) ? tgt_angle : next_r;

  // Ramp offset rounded half away from the start angle.
  assign rnd  = mul_prod[AW+16:0] + (AW+17)'(32768);
  assign dval = rnd[AW+15:16];

  // Duty numerator: (pulse sum * DMAX) * 2 + period * A180.
  assign psum = (PW+1)'(lo_r) + mul_prod[PW:0];
  assign numv = {psum, {DB{1'b0}}} - (PW+DB+1)'(psum);
  assign nv   = {numv, 1'b0} + NWID'(den_r);
  assign sat  = (num_r >= NWID'({den_r, {(DB+1){1'b0}}}));

  assign s_tready = (state == S_IDLE) && !pend && !booting;

  ssrc_smul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  ssrc_sdiv #(.NW(32), .DW(16), .QB(16)) u_pdiv (
    .clk   (clk),
    .rst   (rst),
    .start (pdiv_start),
    .num   ({elapsed[15:0], 16'h0000}),
    .den   (ramp_time),
    .quo   (pdiv_q),
    .done  (pdiv_done)
  );

  ssrc_sdiv #(.NW(PW + DB + 1), .DW(PW + 1), .QB(DB)) u_qdiv (
    .clk   (clk),
    .rst   (rst),
    .start (qdiv_start),
    .num   (num_r[PW+DB:0]),
    .den   ({den_r, 1'b0}),
    .quo   (qdiv_q),
    .done  (qdiv_done)
  );

  // Configuration writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_min   <= 16'd500;
      pulse_max   <= 16'd2500;
      pwm_period  <= 16'd20000;
      ramp_time   <= 16'd1000;
      ramp_step   <= 16'd20;
      settle_time <= 16'd500;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PULSE_MIN:  pulse_min   <= cfg_wdata;
        REG_PULSE_MAX:  pulse_max   <= cfg_wdata;
        REG_PWM_PERIOD: pwm_period  <= cfg_wdata;
        REG_RAMP_TIME:  ramp_time   <= cfg_wdata;
        REG_RAMP_STEP:  ramp_step   <= cfg_wdata;
        REG_SETTLE:     settle_time <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // Reset starts the duty computation for 90 degrees straight away.
      state           <= S_MDEN;
      booting         <= 1'b1;
      pend            <= 1'b0;
      m_tvalid        <= 1'b0;
      cur_angle       <= A90;
      tgt_angle       <= A90;
      ramp_origin     <= A90;
      command_stamp   <= '0;
      last_step_stamp <= '0;
      settle_stamp    <= '0;
      in_motion       <= 1'b0;
      goal_reached    <= 1'b1;
      wrote           <= 1'b0;
      duty_a          <= A90;
      mul_a           <= MUL_AW'(20000);
      mul_b           <= MUL_BW'(A180);
      mul_start       <= 1'b1;
      pdiv_start      <= 1'b0;
      qdiv_start      <= 1'b0;
    end else begin
      mul_start  <= 1'b0;
      pdiv_start <= 1'b0;
      qdiv_start <= 1'b0;

      // Hand the finished result to the output register once it is free.
      if (pend && (!m_tvalid || m_tready)) begin
        m_tdata  <= OUT_W'({in_motion, tgt_angle, cur_angle, wrote, duty_reg});
        m_tvalid <= 1'b1;
        pend     <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            op_r    <= s_tuser;
            now_r   <= s_tdata[31:0];
            goal_r  <= s_tdata[47:32];
            force_r <= s_tdata[48];
            wrote   <= 1'b0;
            state   <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= S_IDLE;
          pend  <= 1'b1;
          if (op_r == OP_MOVE) begin
            if (!same || force_r) begin
              ramp_origin     <= cur_angle;
              tgt_angle       <= goal_c;
              command_stamp   <= now_r;
              last_step_stamp <= now_r;
              settle_stamp    <= now_r;
              in_motion       <= 1'b1;
              wrote           <= 1'b1;
              pend            <= 1'b0;
              if (same) begin
                // Forced re-apply of an unchanged target jumps straight there.
                goal_reached <= 1'b1;
                cur_angle    <= goal_c;
                duty_a       <= goal_c;
                mul_a        <= MUL_AW'(per_eff);
                mul_b        <= MUL_BW'(A180);
                mul_start    <= 1'b1;
                state        <= S_MDEN;
              end else begin
                goal_reached <= 1'b0;
                state        <= S_RAMP;
              end
            end
          end else if (in_motion) begin
            if (!goal_reached) begin
              if (now_r - last_step_stamp >= 32'(ramp_step)) begin
                wrote <= 1'b1;
                pend  <= 1'b0;
                state <= S_RAMP;
              end
            end else if (now_r - settle_stamp >= 32'(settle_time)) begin
              in_motion <= 1'b0;
            end
          end
        end
        S_RAMP: begin
          if ((ramp_time == 16'd0) || (elapsed >= 32'(ramp_time))) begin
            next_r <= tgt_angle;
            state  <= S_NEXT;
          end else begin
            pdiv_start <= 1'b1;
            state      <= S_PDIV;
          end
        end
        S_PDIV: begin
          if (pdiv_done) begin
            p_r       <= pdiv_q;
            mul_a     <= MUL_AW'(pdiv_q);
            mul_b     <= MUL_BW'(pdiv_q);
            mul_start <= 1'b1;
            state     <= S_MPP;
          end
        end
        S_MPP: begin
          if (mul_done) begin
            mul_a     <= mul_prod[MUL_AW-1:0];
            mul_b     <= EASE_K - {1'b0, p_r, 1'b0};
            mul_start <= 1'b1;
            state     <= S_MEASE;
          end
        end
        S_MEASE: begin
          if (mul_done) begin
            // Eased progress is the product's upper part, Q2.16.
            mul_a     <= MUL_AW'(ramp_dist);
            mul_b     <= mul_prod[MUL_AW+MUL_BW-1:MUL_AW];
            mul_start <= 1'b1;
            state     <= S_MD;
          end
        end
        S_MD: begin
          if (mul_done) begin
            next_r <= (tgt_angle >= ramp_origin) ? ramp_origin + dval : ramp_origin - dval;
            state  <= S_NEXT;
          end
        end
        S_NEXT: begin
          cur_angle       <= final_angle;
          last_step_stamp <= now_r;
          duty_a          <= final_angle;
          if (final_angle == tgt_angle) begin
            goal_reached <= 1'b1;
            settle_stamp <= now_r;
          end
          mul_a     <= MUL_AW'(per_eff);
          mul_b     <= MUL_BW'(A180);
          mul_start <= 1'b1;
          state     <= S_MDEN;
        end
        S_MDEN: begin
          if (mul_done) begin
            den_r     <= mul_prod[PW-1:0];
            mul_a     <= MUL_AW'(pulse_min);
            mul_b     <= MUL_BW'(A180 - duty_a);
            mul_start <= 1'b1;
            state     <= S_MLO;
          end
        end
        S_MLO: begin
          if (mul_done) begin
            lo_r      <= mul_prod[PW-1:0];
            mul_a     <= MUL_AW'(pulse_max);
            mul_b     <= MUL_BW'(duty_a);
            mul_start <= 1'b1;
            state     <= S_MHI;
          end
        end
        S_MHI: begin
          if (mul_done) begin
            num_r <= nv;
            state <= S_SAT;
          end
        end
        S_SAT: begin
          if (sat) begin
            duty_reg <= DMAX;
            state    <= S_IDLE;
            booting  <= 1'b0;
            pend     <= !booting;
          end else begin
            qdiv_start <= 1'b1;
            state      <= S_QDIV;
          end
        end
        S_QDIV: begin
          if (qdiv_done) begin
            duty_reg <= qdiv_q;
            state    <= S_IDLE;
            booting  <= 1'b0;
            pend     <= !booting;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The output angle and target never leave the 0..180 degree range.
  a_cur_range: assert property (@(posedge clk) disable iff (rst) cur_angle <= A180)
    else $error("current angle beyond 180 degrees");

  a_tgt_range: assert property (@(posedge clk) disable iff (rst) tgt_angle <= A180)
    else $error("target angle beyond 180 degrees");

  // Motion only ends once the target has been reached.
  a_idle_reached: assert property (@(posedge clk) disable iff (rst)
    !in_motion |-> goal_reached)
    else $error("motion stopped short of the target");

  // An accepted transaction is decoded in the very next cycle.
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_DECODE))
    else $error("accepted transaction not decoded");

endmodule
